// File: hdl/line_source_potential_avg_defines.svh
// Assertion macros shared by the line source potential averaging block.
// No dependencies; included by the files that carry assertions.
`ifndef LINE_SOURCE_POTENTIAL_AVG_DEFINES_SVH
`define LINE_SOURCE_POTENTIAL_AVG_DEFINES_SVH

// Same-cycle implication under the active-low reset.
`define LSPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("line source potential assertion failed");

// Next-cycle implication under the active-low reset.
`define LSPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("line source potential assertion failed");

`endif

// File: hdl/lspa_pkg.sv
// Package for the line source potential averaging block.
// Holds fixed widths, constants, datapath operations and control structs.
package lspa_pkg;

  localparam int DW       = 64;
  localparam int SUM_W    = 48;
  localparam int DIV_W    = 48;
  localparam int LOG_FRAC = 28;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int PCNT_W   = 13;

  localparam logic [27:0] KCOEF = 28'd236905676;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LZERO,
    OP_NORM,
    OP_SQA,
    OP_SQB,
    OP_SQRT,
    OP_ROOT,
    OP_NUMDEN,
    OP_BAD,
    OP_LOGI,
    OP_LZ,
    OP_LSQI,
    OP_LSQ,
    OP_LSTORE,
    OP_MUL0,
    OP_MUL1,
    OP_DIVI,
    OP_DIV,
    OP_SCALE,
    OP_ACC,
    OP_MEAN
  } lspa_op_e;

  typedef struct packed {
    lspa_op_e op;
    logic     sel;
    logic     load;
    logic     out_load;
  } lspa_cmd_t;

  typedef struct packed {
    logic norm_ok;
    logic cnt_last;
    logic lz_top;
    logic l_zero;
    logic bad;
    logic grp_last;
    logic out_free;
  } lspa_stat_t;

endpackage

// File: hdl/lspa_in_if.sv
// Input channel of the line source potential averaging block.
// Carries one observation point per transfer; no package dependency.
interface lspa_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_pos;
  logic signed [COORD_WIDTH-1:0] y_pos;

  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

// File: hdl/lspa_out_if.sv
// Output channel of the line source potential averaging block.
// Carries one point result per transfer; no package dependency.
interface lspa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_potential;
  logic signed [31:0] mean_potential;
  logic               is_last;
  logic               fault;

  modport source (output valid, output point_potential, output mean_potential,
                  output is_last, output fault, input ready);
  modport sink (input valid, input point_potential, input mean_potential,
                input is_last, input fault, output ready);
endinterface

// File: hdl/line_source_potential_avg.sv
// Top level of the line source potential averaging block.
// Joins lspa_ctrl and lspa_datapath; depends on lspa_pkg, the channel
// interfaces and line_source_potential_avg_defines.svh.
//
// One observation point is taken at a time. Unless the configured length is zero,
// each point runs two distance calculations (a normalising shift, the squares
// of both offsets, a 32-step square root and a hand-over each); unless the
// numerator or denominator is not positive, it then runs two base-2 logarithms
// (a leading-one search, a set-up, 28 squaring steps and a store each), two
// partial products and a 48-step divide. A point that closes a group runs the
// same divider once more to form the mean. A new point is accepted in the
// cycle after its result moves to the output register, which holds it until
// the transfer completes.
`include "line_source_potential_avg_defines.svh"

module line_source_potential_avg #(
  parameter int MAX_POINTS  = 4096,
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lspa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lspa_pkg::CFG_W-1:0]     cfg_data_i,
  lspa_in_if.sink                        in_i,
  lspa_out_if.source                     out_o
);
  import lspa_pkg::*;

  lspa_cmd_t  cmd;
  lspa_stat_t stat;

  lspa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lspa_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .x_pos_i           (in_i.x_pos),
    .y_pos_i           (in_i.y_pos),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .point_potential_o (out_o.point_potential),
    .mean_potential_o  (out_o.mean_potential),
    .is_last_o         (out_o.is_last),
    .fault_o           (out_o.fault)
  );

  `LSPA_ASSERT_IMP(a_mean_zero, clk_i, rst_ni, out_o.valid && !out_o.is_last, out_o.mean_potential == 0)
  `LSPA_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `LSPA_ASSERT_NXT(a_out_loaded, clk_i, rst_ni, cmd.out_load, out_o.valid)

endmodule

// File: hdl/lspa_datapath.sv
// Datapath of the line source potential averaging block: distances, logarithms,
// scaling, accumulation and the output register. Depends on lspa_pkg.
module lspa_datapath #(
  parameter int MAX_POINTS  = 4096,
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lspa_pkg::lspa_cmd_t               cmd_i,
  output lspa_pkg::lspa_stat_t              stat_o,
  input  logic                              cfg_we_i,
  input  logic [lspa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lspa_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic signed [COORD_WIDTH-1:0]     x_pos_i,
  input  logic signed [COORD_WIDTH-1:0]     y_pos_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [31:0]                point_potential_o,
  output logic signed [31:0]                mean_potential_o,
  output logic                              is_last_o,
  output logic                              fault_o
);
  import lspa_pkg::*;

  logic [31:0]          len_q;
  logic [PCNT_W-1:0]    pcnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [PCNT_W-1:0]    seen_q;
  logic                 out_valid_q;

  logic signed [DW-1:0] x_q, y_q, r1_q, r2_q, num_q, den_q;
  logic [DW-1:0]        ha_q, hb_q, sq_q, lz_q;
  logic [5:0]           sh_q, cnt_q, lk_q;
  logic [35:0]          rem_q;
  logic [31:0]          root_q, z_q;
  logic [LOG_FRAC-1:0]  frac_q;
  logic [33:0]          logn_q, dmag_q;
  logic                 neg_q;
  logic [61:0]          prod_q;
  logic [DIV_W-1:0]     dvn_q;
  logic [31:0]          dvr_q, dvd_q;
  logic signed [31:0]   pv_q, mean_q;
  logic                 flt_q, last_q;
  logic signed [31:0]   opv_q, omean_q;
  logic                 olast_q, oflt_q;

  logic signed [DW-1:0] x_ext, y_ext, len64, lmx, r_shift, sel_a;
  logic [DW-1:0]        mag_x, mag_y, mag_lmx;
  logic [61:0]          sqa, sqb;
  logic [35:0]          rem_n, trial;
  logic [63:0]          zz;
  logic [32:0]          zt;
  logic [33:0]          logv;
  logic signed [34:0]   dlog;
  logic [44:0]          mul_p;
  logic [32:0]          dv_rn;
  logic signed [SUM_W-1:0] sum_n;
  logic [PCNT_W-1:0]    n_eff;
  logic                 grp_last;
  logic                 out_free;

  assign x_ext   = {{(DW-COORD_WIDTH){x_pos_i[COORD_WIDTH-1]}}, x_pos_i};
  assign y_ext   = {{(DW-COORD_WIDTH){y_pos_i[COORD_WIDTH-1]}}, y_pos_i};
  assign mag_x   = x_ext[DW-1] ? DW'(-x_ext) : DW'(x_ext);
  assign mag_y   = y_ext[DW-1] ? DW'(-y_ext) : DW'(y_ext);
  assign len64   = {32'd0, len_q};
  assign lmx     = len64 - x_q;
  assign mag_lmx = lmx[DW-1] ? DW'(-lmx) : DW'(lmx);

  assign sqa     = ha_q[30:0] * ha_q[30:0];
  assign sqb     = hb_q[30:0] * hb_q[30:0];
  assign rem_n   = {rem_q[33:0], sq_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign r_shift = {32'd0, root_q} << sh_q;
  assign sel_a   = (r1_q > r2_q) ? r1_q : r2_q;

  assign zz      = z_q * z_q;
  assign zt      = zz[63:31];
  assign logv    = {lk_q, frac_q};
  assign dlog    = $signed({1'b0, logn_q}) - $signed({1'b0, logv});
  assign mul_p   = (cmd_i.op == OP_MUL0) ? dmag_q[16:0] * KCOEF : dmag_q[33:17] * KCOEF;
  assign dv_rn   = {dvr_q, dvn_q[DIV_W-1]};

  assign sum_n   = sum_q + {{(SUM_W-32){pv_q[31]}}, pv_q};
  always_comb begin
    if (pcnt_q == '0) begin
      n_eff = PCNT_W'(1);
    end else if (int'(pcnt_q) > MAX_POINTS) begin
      n_eff = PCNT_W'(MAX_POINTS);
    end else begin
      n_eff = pcnt_q;
    end
  end
  assign grp_last = ({1'b0, seen_q} + 14'd1) >= {1'b0, n_eff};
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.norm_ok  = (ha_q[DW-1:31] == '0) && (hb_q[DW-1:31] == '0);
  assign stat_o.cnt_last = (cnt_q == 6'd1);
  assign stat_o.lz_top   = lz_q[DW-1];
  assign stat_o.l_zero   = (len_q == '0);
  assign stat_o.bad      = (num_q <= 0) || (den_q <= 0);
  assign stat_o.grp_last = grp_last;
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 32'd65536;
      pcnt_q      <= PCNT_W'(16);
      sum_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LENGTH: len_q  <= cfg_data_i;
          CFG_COUNT:  pcnt_q <= cfg_data_i[PCNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_ACC) begin
        if (grp_last) begin
          sum_q  <= '0;
          seen_q <= '0;
        end else begin
          sum_q  <= sum_n;
          seen_q <= seen_q + PCNT_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= x_ext;
      y_q  <= y_ext;
      ha_q <= mag_x;
      hb_q <= mag_y;
      sh_q <= '0;
    end
    if (cmd_i.out_load) begin
      opv_q   <= pv_q;
      omean_q <= mean_q;
      olast_q <= last_q;
      oflt_q  <= flt_q;
    end
    case (cmd_i.op)
      OP_LZERO: begin
        pv_q  <= '0;
        flt_q <= 1'b1;
      end
      OP_NORM: begin
        if (!stat_o.norm_ok) begin
          ha_q <= ha_q >> 1;
          hb_q <= hb_q >> 1;
          sh_q <= sh_q + 6'd1;
        end
      end
      OP_SQA: sq_q <= {2'b00, sqa};
      OP_SQB: begin
        sq_q   <= sq_q + {2'b00, sqb};
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= 6'd32;
      end
      OP_SQRT: begin
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[30:0], 1'b0};
        end
        sq_q  <= sq_q << 2;
        cnt_q <= cnt_q - 6'd1;
      end
      OP_ROOT: begin
        if (!cmd_i.sel) begin
          r1_q <= r_shift;
          ha_q <= mag_lmx;
          hb_q <= y_q[DW-1] ? DW'(-y_q) : DW'(y_q);
          sh_q <= '0;
        end else begin
          r2_q <= r_shift;
        end
      end
      OP_NUMDEN: begin
        if (r1_q == x_q) begin
          num_q <= sel_a;
          den_q <= sel_a - len64;
        end else begin
          num_q <= len64 - x_q + r2_q;
          den_q <= r1_q - x_q;
        end
      end
      OP_BAD: begin
        pv_q  <= (num_q <= 0) ? S32_MIN : S32_MAX;
        flt_q <= 1'b1;
      end
      OP_LOGI: begin
        lz_q <= num_q;
        lk_q <= 6'd63;
      end
      OP_LZ: begin
        if (lz_q[DW-1:DW-16] == '0) begin
          lz_q <= lz_q << 16;
          lk_q <= lk_q - 6'd16;
        end else if (!lz_q[DW-1]) begin
          lz_q <= lz_q << 1;
          lk_q <= lk_q - 6'd1;
        end
      end
      OP_LSQI: begin
        z_q    <= lz_q[DW-1:DW-32];
        frac_q <= '0;
        cnt_q  <= 6'(LOG_FRAC);
      end
      OP_LSQ: begin
        if (zt[32]) begin
          z_q    <= zt[32:1];
          frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
        end else begin
          z_q    <= zt[31:0];
          frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
      end
      OP_LSTORE: begin
        if (!cmd_i.sel) begin
          logn_q <= logv;
          lz_q   <= den_q;
          lk_q   <= 6'd63;
        end else begin
          neg_q  <= dlog[34];
          dmag_q <= dlog[34] ? 34'(-dlog) : dlog[33:0];
        end
      end
      OP_MUL0: prod_q <= {17'd0, mul_p};
      OP_MUL1: prod_q <= prod_q + {mul_p, 17'd0};
      OP_DIVI: begin
        dvn_q <= {6'd0, prod_q[61:20]};
        dvd_q <= len_q;
        dvr_q <= '0;
        cnt_q <= 6'(DIV_W);
      end
      OP_DIV: begin
        if (dv_rn >= {1'b0, dvd_q}) begin
          dvr_q <= 32'(dv_rn - {1'b0, dvd_q});
          dvn_q <= {dvn_q[DIV_W-2:0], 1'b1};
        end else begin
          dvr_q <= dv_rn[31:0];
          dvn_q <= {dvn_q[DIV_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
      end
      OP_SCALE: begin
        if (!neg_q) begin
          if (dvn_q > DIV_W'(S32_MAX)) begin
            pv_q  <= S32_MAX;
            flt_q <= 1'b1;
          end else begin
            pv_q  <= dvn_q[31:0];
            flt_q <= 1'b0;
          end
        end else begin
          if (dvn_q > DIV_W'(S32_MIN)) begin
            pv_q  <= S32_MIN;
            flt_q <= 1'b1;
          end else begin
            pv_q  <= -dvn_q[31:0];
            flt_q <= 1'b0;
          end
        end
      end
      OP_ACC: begin
        last_q <= grp_last;
        mean_q <= '0;
        neg_q  <= sum_n[SUM_W-1];
        dvn_q  <= sum_n[SUM_W-1] ? DIV_W'(-sum_n) : DIV_W'(sum_n);
        dvd_q  <= {19'd0, n_eff};
        dvr_q  <= '0;
        cnt_q  <= 6'(DIV_W);
      end
      OP_MEAN: mean_q <= neg_q ? -dvn_q[31:0] : dvn_q[31:0];
      default: begin
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign point_potential_o = opv_q;
  assign mean_potential_o  = omean_q;
  assign is_last_o         = olast_q;
  assign fault_o           = oflt_q;

endmodule

// File: hdl/lspa_ctrl.sv
// Sequencing state machine of the line source potential averaging block.
// Issues datapath operations from status flags; depends on lspa_pkg.
module lspa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lspa_pkg::lspa_stat_t stat_i,
  output lspa_pkg::lspa_cmd_t  cmd_o
);
  import lspa_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE   = 22'd1,
    S_LZERO  = 22'd2,
    S_NORM   = 22'd4,
    S_SQA    = 22'd8,
    S_SQB    = 22'd16,
    S_SQRT   = 22'd32,
    S_ROOT   = 22'd64,
    S_NUMDEN = 22'd128,
    S_CHK    = 22'd256,
    S_LZ     = 22'd512,
    S_LSQI   = 22'd1024,
    S_LSQ    = 22'd2048,
    S_LSTORE = 22'd4096,
    S_MUL0   = 22'd8192,
    S_MUL1   = 22'd16384,
    S_DIVI   = 22'd32768,
    S_DIV    = 22'd65536,
    S_SCALE  = 22'd131072,
    S_ACC    = 22'd262144,
    S_MDIV   = 22'd524288,
    S_MEAN   = 22'd1048576,
    S_DONE   = 22'd2097152
  } lspa_state_e;

  lspa_state_e state_q, state_d;
  logic        sel_q, sel_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    sel_d            = sel_q;
    cmd_o.op         = OP_NONE;
    cmd_o.sel        = sel_q;
    cmd_o.load       = 1'b0;
    cmd_o.out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        sel_d = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.l_zero ? S_LZERO : S_NORM;
        end
      end
      S_LZERO: begin
        cmd_o.op = OP_LZERO;
        state_d  = S_ACC;
      end
      S_NORM: begin
        cmd_o.op = OP_NORM;
        if (stat_i.norm_ok) begin
          state_d = S_SQA;
        end
      end
      S_SQA: begin
        cmd_o.op = OP_SQA;
        state_d  = S_SQB;
      end
      S_SQB: begin
        cmd_o.op = OP_SQB;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (stat_i.cnt_last) begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = S_NORM;
        end else begin
          state_d = S_NUMDEN;
        end
      end
      S_NUMDEN: begin
        cmd_o.op = OP_NUMDEN;
        state_d  = S_CHK;
      end
      S_CHK: begin
        sel_d = 1'b0;
        if (stat_i.bad) begin
          cmd_o.op = OP_BAD;
          state_d  = S_ACC;
        end else begin
          cmd_o.op = OP_LOGI;
          state_d  = S_LZ;
        end
      end
      S_LZ: begin
        cmd_o.op = OP_LZ;
        if (stat_i.lz_top) begin
          state_d = S_LSQI;
        end
      end
      S_LSQI: begin
        cmd_o.op = OP_LSQI;
        state_d  = S_LSQ;
      end
      S_LSQ: begin
        cmd_o.op = OP_LSQ;
        if (stat_i.cnt_last) begin
          state_d = S_LSTORE;
        end
      end
      S_LSTORE: begin
        cmd_o.op = OP_LSTORE;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = S_LZ;
        end else begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.op = OP_MUL0;
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.op = OP_DIVI;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.cnt_last) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = stat_i.grp_last ? S_MDIV : S_DONE;
      end
      S_MDIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.cnt_last) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.op = OP_MEAN;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// File: test/line_source_potential_avg_tb.sv
// Self-checking testbench for line_source_potential_avg: per-point potential
// coefficients and group means are predicted in SystemVerilog and compared per transfer.
// Depends on lspa_pkg, lspa_in_if, lspa_out_if and the block itself.
module line_source_potential_avg_tb;
  import lspa_pkg::*;

  localparam longint K_LN2_4PI = 64'd236905676;
  localparam int     MAX_PTS   = 4096;
  localparam int     CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } obs_point_t;

  typedef struct {
    logic signed [31:0] point_potential;
    logic signed [31:0] mean_potential;
    logic               is_last;
    logic               fault;
  } coeff_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  lspa_in_if #(.COORD_WIDTH(32)) in_ch();
  lspa_out_if                    out_ch();

  line_source_potential_avg DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  obs_point_t    point_q[$];
  coeff_result_t coeff_q[$];
  logic [31:0]   seg_len;
  logic [31:0]   cond_radius;
  logic [12:0]   pcount;
  longint        group_sum;
  int            group_seen;
  int            errors;
  int            accepted;
  int            send_idle;
  int            recv_idle;
  int            cycles;
  logic          in_took;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit [63:0] int_sqrt(bit [63:0] n);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] dist_hyp(bit [63:0] a, bit [63:0] b);
    int        s;
    bit [63:0] as;
    bit [63:0] bs;
    s = 0;
    while ((a >> s) >= (64'd1 << 31) || (b >> s) >= (64'd1 << 31)) s++;
    as = a >> s;
    bs = b >> s;
    return int_sqrt(as * as + bs * bs) << s;
  endfunction

  function automatic bit [63:0] magn(longint v);
    return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint log2_q28(bit [63:0] p);
    int        k;
    bit [63:0] z;
    bit [63:0] frac;
    k = 63;
    while (!p[k]) k--;
    z = (k >= 31) ? (p >> (k - 31)) : (p << (31 - k));
    frac = 0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      z = (z * z) >> 31;
      frac = frac << 1;
      if (z >= (64'd1 << 32)) begin
        z = z >> 1;
        frac = frac | 64'd1;
      end
    end
    return (longint'(k) << LOG_FRAC) | longint'(frac);
  endfunction

  function automatic logic signed [31:0] point_coeff(longint x, longint y, output logic flt);
    longint len;
    longint r1;
    longint r2;
    longint a;
    longint num;
    longint den;
    longint d;
    longint v;
    len = longint'({32'd0, seg_len});
    flt = 1'b0;
    if (len == 0) begin
      flt = 1'b1;
      return 32'sd0;
    end
    r1 = longint'(dist_hyp(magn(x), magn(y)));
    r2 = longint'(dist_hyp(magn(len - x), magn(y)));
    if (r1 == x) begin
      a = (r1 > r2) ? r1 : r2;
      num = a;
      den = a - len;
    end else begin
      num = len - x + r2;
      den = r1 - x;
    end
    if (num <= 0) begin
      flt = 1'b1;
      return S32_MIN;
    end
    if (den <= 0) begin
      flt = 1'b1;
      return S32_MAX;
    end
    d = log2_q28(64'(num)) - log2_q28(64'(den));
    v = (d * K_LN2_4PI) / (len << 20);
    if (v > 64'sd2147483647) begin
      flt = 1'b1;
      return S32_MAX;
    end
    if (v < -64'sd2147483648) begin
      flt = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic coeff_result_t predict_coeff(obs_point_t pt);
    coeff_result_t res;
    logic          flt;
    longint        n;
    res.point_potential = point_coeff(longint'(pt.x), longint'(pt.y), flt);
    res.fault = flt;
    n = longint'(pcount);
    if (n < 1) n = 1;
    if (n > MAX_PTS) n = MAX_PTS;
    group_sum = group_sum + longint'(res.point_potential);
    res.is_last = (longint'(group_seen) + 1 >= n);
    res.mean_potential = 32'sd0;
    if (res.is_last) begin
      res.mean_potential = 32'(group_sum / n);
      group_sum = 0;
      group_seen = 0;
    end else begin
      group_seen = (group_seen + 1) & 32'h1fff;
    end
    return res;
  endfunction

  task automatic add_point(longint x, longint y);
    obs_point_t pt;
    pt.x = x[31:0];
    pt.y = y[31:0];
    point_q.push_back(pt);
  endtask

  task automatic add_random_points(int count);
    longint len;
    longint n;
    longint i;
    longint x;
    longint y;
    int     sel;
    len = longint'({32'd0, seg_len});
    n = longint'(pcount);
    if (n < 1) n = 1;
    if (n > MAX_PTS) n = MAX_PTS;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        i = $urandom_range(int'(n) - 1);
        x = ((2 * i + 1) * len) / (2 * n);
        y = longint'({32'd0, cond_radius});
        if ($urandom_range(3) == 0) y = y + $urandom_range(64) - 32;
        if ($urandom_range(7) == 0) y = -y;
      end else if (sel < 75) begin
        x = longint'($urandom_range(4 * 65536)) * (len / 65536 + 1) - len;
        y = longint'($signed($urandom_range(131072))) - 65536;
      end else if (sel < 85) begin
        x = longint'($signed($urandom()));
        y = 0;
      end else begin
        x = longint'($signed($urandom()));
        y = longint'($signed($urandom()));
      end
      add_point(x, y);
    end
  endtask

  task automatic wait_idle();
    while (point_q.size() != 0 || coeff_q.size() != 0 || in_ch.valid) @(posedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_LENGTH: seg_len = value;
      CFG_RADIUS: cond_radius = value;
      CFG_COUNT:  pcount = value[12:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] len, logic [31:0] rad, logic [31:0] cnt);
    wait_idle();
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_COUNT, cnt);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.x_pos  = '0;
    in_ch.y_pos  = '0;
    out_ch.ready = 1'b0;
    seg_len      = 32'd65536;
    cond_radius  = 32'd655;
    pcount       = 13'd16;
    group_sum    = 0;
    group_seen   = 0;
    errors       = 0;
    accepted     = 0;
    send_idle    = 14;
    recv_idle    = 79;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_point(0, 0);
    add_point(65536, 0);
    add_point(32768, 0);
    add_point(-65536, 0);
    add_point(131072, 0);
    add_point(32768, 655);
    add_point(32768, -655);
    add_point(2147483647, 2147483647);
    add_point(-2147483648, -2147483648);
    add_point(2147483647, -2147483648);
    add_point(-2147483648, 2147483647);
    add_point(0, 2147483647);
    add_point(0, -2147483648);
    add_point(2147483647, 0);
    add_point(-2147483648, 0);
    add_point(1, 1);
    add_point(-1, -1);
    add_point(65536, 1);
    set_config(32'd0, 32'd0, 32'd3);
    add_point(32768, 655);
    add_point(-5, 7);
    add_point(100, 0);
    wait_idle();
    write_reg(CFG_UNUSED, 32'hffff_ffff);
    set_config(32'd1, 32'd0, 32'd1);
    add_point(0, 1);
    add_point(1, 0);
    add_point(-2147483648, 1);

    set_config(32'd65536, 32'd655, 32'd16);
    add_random_points(300);
    set_config(32'hffff_ffff, 32'hffff_ffff, 32'd4096);
    add_random_points(150);
    set_config($urandom(), $urandom(), 32'd0);
    add_random_points(200);
    set_config(32'd327680, 32'd1000, 32'd7);
    add_random_points(300);
    set_config($urandom_range(32'h00ff_ffff, 1), $urandom_range(4000), 32'd8191);
    add_random_points(100);
    set_config(32'd6554, 32'd66, 32'd5);
    add_random_points(350);
    set_config($urandom(), $urandom_range(65536), $urandom_range(64, 1));
    add_random_points(400);

    wait_idle();
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS line_source_potential_avg");
    end else begin
      $display("FAIL line_source_potential_avg");
    end
    $finish;
  end

  always @(negedge clk_i) begin : drive_points
    obs_point_t pt;
    if (rst_ni) begin
      if (!in_ch.valid || in_took) begin
        if (point_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          pt = point_q.pop_front();
          in_ch.x_pos <= pt.x;
          in_ch.y_pos <= pt.y;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin : watch_transfers
    obs_point_t    pt;
    coeff_result_t exp_res;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      pt.x = in_ch.x_pos;
      pt.y = in_ch.y_pos;
      coeff_q.push_back(predict_coeff(pt));
      accepted = accepted + 1;
      if (accepted == 600) begin
        send_idle = 79;
        recv_idle = 14;
      end else if (accepted == 1200) begin
        send_idle = 0;
        recv_idle = 0;
      end
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (coeff_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pp=%h mean=%h last=%b fault=%b", $time,
                 out_ch.point_potential, out_ch.mean_potential, out_ch.is_last,
                 out_ch.fault);
      end else begin
        exp_res = coeff_q.pop_front();
        if (out_ch.point_potential !== exp_res.point_potential ||
            out_ch.mean_potential !== exp_res.mean_potential ||
            out_ch.is_last !== exp_res.is_last || out_ch.fault !== exp_res.fault) begin
          errors++;
          $display("%0t: mismatch expected pp=%h mean=%h last=%b fault=%b", $time,
                   exp_res.point_potential, exp_res.mean_potential, exp_res.is_last,
                   exp_res.fault);
          $display("%0t:          actual   pp=%h mean=%h last=%b fault=%b", $time,
                   out_ch.point_potential, out_ch.mean_potential, out_ch.is_last,
                   out_ch.fault);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAIL line_source_potential_avg");
        $finish;
      end
    end
  end
endmodule

// File: files.f
+incdir+hdl
hdl/lspa_pkg.sv
hdl/lspa_in_if.sv
hdl/lspa_out_if.sv
hdl/lspa_datapath.sv
hdl/lspa_ctrl.sv
hdl/line_source_potential_avg.sv
test/line_source_potential_avg_tb.sv
